FILE: design/rqt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rqt_pkg;

    // read length limit and fixed field widths
    localparam int MAX_READ_LEN = 4096;
    localparam int Q_W          = 8;
    localparam int MINLEN_W     = 13;
    localparam int OUT_W        = 12;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_BOTH  = 2'd2,
        MODE_RUN   = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_MIN_LENGTH = 2'd1,
        REG_TRIM_MODE = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [Q_W-1:0]      threshold;
        logic [MINLEN_W-1:0] min_length;
        mode_t               mode;
    } cfg_t;

    localparam logic [Q_W-1:0]      THRESHOLD_RESET  = 8'd48;
    localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = 13'd25;
    localparam mode_t               MODE_RESET       = MODE_RIGHT;

endpackage

`default_nettype wire

FILE: design/rqt_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module rqt_tracker #(
    parameter int MAX_READ_LEN = rqt_pkg::MAX_READ_LEN,
    localparam int POS_W = $clog2(MAX_READ_LEN + 1),
    localparam int IDX_W = $clog2(MAX_READ_LEN),
    localparam int SUM_W = $clog2(MAX_READ_LEN * 255 + 1) + 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [rqt_pkg::Q_W-1:0]     threshold,
    input  wire logic                        base_valid,
    input  wire logic [rqt_pkg::Q_W-1:0]     base_quality,
    input  wire logic                        base_last,
    input  wire logic                        snap_ready,
    output logic                             snap_free,
    output logic                             snap_valid,
    output logic [POS_W-1:0]                 snap_len,
    output logic signed [SUM_W-1:0]          snap_total,
    output logic signed [SUM_W-1:0]          snap_min,
    output logic [IDX_W-1:0]                 snap_min_idx,
    output logic signed [SUM_W-1:0]          snap_max,
    output logic [IDX_W-1:0]                 snap_max_idx,
    output logic [IDX_W-1:0]                 snap_run_begin,
    output logic [POS_W-1:0]                 snap_run_len
);

    // running per-read trackers
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] min_reg, min_next;
    logic [IDX_W-1:0]        min_idx_reg, min_idx_next;
    logic signed [SUM_W-1:0] max_reg, max_next;
    logic [IDX_W-1:0]        max_idx_reg, max_idx_next;
    logic                    in_run_reg, in_run_next;
    logic [IDX_W-1:0]        run_begin_reg, run_begin_next;
    logic [IDX_W-1:0]        best_begin_reg, best_begin_next;
    logic [POS_W-1:0]        best_len_reg, best_len_next;

    // snapshot of a finished read
    logic                    snap_valid_reg, snap_valid_next;
    logic [POS_W-1:0]        snap_len_reg;
    logic signed [SUM_W-1:0] snap_total_reg;
    logic signed [SUM_W-1:0] snap_min_reg;
    logic [IDX_W-1:0]        snap_min_idx_reg;
    logic signed [SUM_W-1:0] snap_max_reg;
    logic [IDX_W-1:0]        snap_max_idx_reg;
    logic [IDX_W-1:0]        snap_run_begin_reg;
    logic [POS_W-1:0]        snap_run_len_reg;

    // updated values before the end-of-read clear
    logic [POS_W-1:0]        upd_pos;
    logic signed [SUM_W-1:0] upd_sum;
    logic signed [SUM_W-1:0] upd_min;
    logic [IDX_W-1:0]        upd_min_idx;
    logic signed [SUM_W-1:0] upd_max;
    logic [IDX_W-1:0]        upd_max_idx;
    logic                    upd_in_run;
    logic [IDX_W-1:0]        upd_run_begin;
    logic [IDX_W-1:0]        upd_best_begin;
    logic [POS_W-1:0]        upd_best_len;

    logic                    take;
    logic                    first;
    logic                    good;
    logic [IDX_W-1:0]        idx;
    logic signed [rqt_pkg::Q_W:0] diff;
    logic signed [SUM_W-1:0] sum_add;
    logic [POS_W-1:0]        run_len;
    logic                    load_snap;

    assign take  = pos_reg < POS_W'(MAX_READ_LEN);
    assign first = pos_reg == '0;
    assign idx   = pos_reg[IDX_W-1:0];
    assign good  = base_quality >= threshold;
    assign diff  = $signed({1'b0, threshold} - {1'b0, base_quality});
    assign sum_add = sum_reg + SUM_W'(diff);

    always_comb
    begin
        upd_pos        = pos_reg;
        upd_sum        = sum_reg;
        upd_min        = min_reg;
        upd_min_idx    = min_idx_reg;
        upd_max        = max_reg;
        upd_max_idx    = max_idx_reg;
        upd_in_run     = in_run_reg;
        upd_run_begin  = run_begin_reg;
        upd_best_begin = best_begin_reg;
        upd_best_len   = best_len_reg;
        run_len        = '0;
        if (take)
        begin
            upd_pos = pos_reg + 1'b1;
            upd_sum = sum_add;
            if (first)
            begin
                upd_min     = sum_add;
                upd_min_idx = '0;
                upd_max     = sum_add;
                upd_max_idx = '0;
            end
            else
            begin
                if (sum_add < min_reg)
                begin
                    upd_min     = sum_add;
                    upd_min_idx = idx;
                end
                if (sum_add > max_reg)
                begin
                    upd_max     = sum_add;
                    upd_max_idx = idx;
                end
            end
            upd_in_run = good;
            if (good && !in_run_reg)
            begin
                upd_run_begin = idx;
            end
            run_len = POS_W'(idx) - POS_W'(upd_run_begin) + 1'b1;
            if (good && (run_len > best_len_reg))
            begin
                upd_best_len   = run_len;
                upd_best_begin = upd_run_begin;
            end
        end
    end

    assign snap_free = !snap_valid_reg || snap_ready;
    assign load_snap = base_valid && base_last;

    always_comb
    begin
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        min_next        = min_reg;
        min_idx_next    = min_idx_reg;
        max_next        = max_reg;
        max_idx_next    = max_idx_reg;
        in_run_next     = in_run_reg;
        run_begin_next  = run_begin_reg;
        best_begin_next = best_begin_reg;
        best_len_next   = best_len_reg;
        if (base_valid)
        begin
            if (base_last)
            begin
                pos_next        = '0;
                sum_next        = '0;
                min_next        = '0;
                min_idx_next    = '0;
                max_next        = '0;
                max_idx_next    = '0;
                in_run_next     = 1'b0;
                run_begin_next  = '0;
                best_begin_next = '0;
                best_len_next   = '0;
            end
            else
            begin
                pos_next        = upd_pos;
                sum_next        = upd_sum;
                min_next        = upd_min;
                min_idx_next    = upd_min_idx;
                max_next        = upd_max;
                max_idx_next    = upd_max_idx;
                in_run_next     = upd_in_run;
                run_begin_next  = upd_run_begin;
                best_begin_next = upd_best_begin;
                best_len_next   = upd_best_len;
            end
        end
    end

    always_comb
    begin
        if (load_snap)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_next = 1'b0;
        end
        else
        begin
            snap_valid_next = snap_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            sum_reg        <= '0;
            min_reg        <= '0;
            min_idx_reg    <= '0;
            max_reg        <= '0;
            max_idx_reg    <= '0;
            in_run_reg     <= 1'b0;
            run_begin_reg  <= '0;
            best_begin_reg <= '0;
            best_len_reg   <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            min_reg        <= min_next;
            min_idx_reg    <= min_idx_next;
            max_reg        <= max_next;
            max_idx_reg    <= max_idx_next;
            in_run_reg     <= in_run_next;
            run_begin_reg  <= run_begin_next;
            best_begin_reg <= best_begin_next;
            best_len_reg   <= best_len_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_snap)
        begin
            snap_len_reg       <= upd_pos;
            snap_total_reg     <= upd_sum;
            snap_min_reg       <= upd_min;
            snap_min_idx_reg   <= upd_min_idx;
            snap_max_reg       <= upd_max;
            snap_max_idx_reg   <= upd_max_idx;
            snap_run_begin_reg <= upd_best_begin;
            snap_run_len_reg   <= upd_best_len;
        end
    end

    assign snap_valid     = snap_valid_reg;
    assign snap_len       = snap_len_reg;
    assign snap_total     = snap_total_reg;
    assign snap_min       = snap_min_reg;
    assign snap_min_idx   = snap_min_idx_reg;
    assign snap_max       = snap_max_reg;
    assign snap_max_idx   = snap_max_idx_reg;
    assign snap_run_begin = snap_run_begin_reg;
    assign snap_run_len   = snap_run_len_reg;

endmodule

`default_nettype wire

FILE: design/rqt_resolve.sv
`timescale 1ns / 1ps
`default_nettype none

module rqt_resolve #(
    parameter int MAX_READ_LEN = rqt_pkg::MAX_READ_LEN,
    localparam int POS_W = $clog2(MAX_READ_LEN + 1),
    localparam int IDX_W = $clog2(MAX_READ_LEN),
    localparam int SUM_W = $clog2(MAX_READ_LEN * 255 + 1) + 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [rqt_pkg::MINLEN_W-1:0]   min_length,
    input  wire rqt_pkg::mode_t                 mode,
    input  wire logic                           snap_valid,
    output logic                                snap_ready,
    input  wire logic [POS_W-1:0]               snap_len,
    input  wire logic signed [SUM_W-1:0]        snap_total,
    input  wire logic signed [SUM_W-1:0]        snap_min,
    input  wire logic [IDX_W-1:0]               snap_min_idx,
    input  wire logic signed [SUM_W-1:0]        snap_max,
    input  wire logic [IDX_W-1:0]               snap_max_idx,
    input  wire logic [IDX_W-1:0]               snap_run_begin,
    input  wire logic [POS_W-1:0]               snap_run_len,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rqt_pkg::OUT_W-1:0]           trim_start,
    output logic [rqt_pkg::OUT_W-1:0]           trim_end,
    output logic                                keep_read
);

    localparam int OutW = rqt_pkg::OUT_W;
    localparam int CmpW = ((POS_W + 1 > rqt_pkg::MINLEN_W) ? POS_W + 1 : rqt_pkg::MINLEN_W) + 1;

    logic                 out_valid_reg, out_valid_next;
    logic [OutW-1:0]      start_reg;
    logic [OutW-1:0]      end_reg;
    logic                 keep_reg;

    logic [POS_W-1:0]     start_val;
    logic [POS_W-1:0]     end_val;
    logic                 right_cut;
    logic                 left_step;
    logic                 keep_val;
    logic                 load;

    assign right_cut = snap_total > snap_min;
    assign left_step = snap_total < snap_max;

    always_comb
    begin
        start_val = '0;
        end_val   = snap_len - 1'b1;
        unique case (mode)
            rqt_pkg::MODE_NONE:
            begin
                start_val = '0;
            end
            rqt_pkg::MODE_RIGHT, rqt_pkg::MODE_BOTH:
            begin
                if (right_cut)
                begin
                    end_val = POS_W'(snap_min_idx);
                end
                if (mode == rqt_pkg::MODE_BOTH)
                begin
                    start_val = POS_W'(snap_max_idx) + POS_W'(left_step);
                end
            end
            rqt_pkg::MODE_RUN:
            begin
                if (snap_run_len != '0)
                begin
                    start_val = POS_W'(snap_run_begin);
                    end_val   = POS_W'(snap_run_begin) + snap_run_len - 1'b1;
                end
                else
                begin
                    end_val = '0;
                end
            end
            default:
            begin
                start_val = '0;
            end
        endcase
    end

    // signed length test rewritten as end + 1 >= start + min_length
    assign keep_val = (CmpW'(end_val) + 1'b1) >= (CmpW'(start_val) + CmpW'(min_length));

    assign snap_ready = !out_valid_reg || out_ready;
    assign load       = snap_valid && snap_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            start_reg <= OutW'(start_val);
            end_reg   <= OutW'(end_val);
            keep_reg  <= keep_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign trim_start = start_reg;
    assign trim_end   = end_reg;
    assign keep_read  = keep_reg;

endmodule

`default_nettype wire

FILE: design/read_quality_trimmer.sv
`timescale 1ns / 1ps
`default_nettype none

// read quality trimmer
//
// input channel (in_valid / in_ready): one transaction per base, carrying the
// raw quality byte and a last_base mark on the final base of a read
// output channel (out_valid / out_ready): one transaction per read, giving
// the first and last kept base index and the keep flag
// config port: cfg_write with cfg_index / cfg_data, taken on the clock edge,
// 0 quality_threshold, 1 min_length, 2 trim_mode; write only while idle
//
// throughput: one base per cycle, sustained unless a last base finds the snapshot
// full, set by the update of the running prefix sum, its first minimum and maximum
// and the run tracker; a finished read moves from the input register through the
// tracker stage to the result register
// bases past MAX_READ_LEN are dropped but their last_base mark still ends the read
//
// when the receiver stalls, up to two finished reads wait (tracker snapshot and
// result register) while bases of the next read keep streaming; in_ready drops
// only when a third last base would have nowhere to go
// reset clears all trackers and restores the register defaults (48, 25, mode 1)

module read_quality_trimmer #(
    parameter int MAX_READ_LEN = rqt_pkg::MAX_READ_LEN
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [rqt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rqt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [rqt_pkg::Q_W-1:0]           quality_code,
    input  wire logic                              last_base,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [rqt_pkg::OUT_W-1:0]              trim_start,
    output logic [rqt_pkg::OUT_W-1:0]              trim_end,
    output logic                                   keep_read
);

    localparam int POS_W = $clog2(MAX_READ_LEN + 1);
    localparam int IDX_W = $clog2(MAX_READ_LEN);
    localparam int SUM_W = $clog2(MAX_READ_LEN * 255 + 1) + 1;

    // configuration registers
    rqt_pkg::cfg_t cfg_reg, cfg_next;

    // input register
    logic                     in_valid_reg, in_valid_next;
    logic [rqt_pkg::Q_W-1:0]  quality_reg;
    logic                     last_reg;

    logic                     in_fire;
    logic                     advance;
    logic                     snap_free;

    // snapshot between tracker and resolve stages
    logic                     snap_valid;
    logic                     snap_ready;
    logic [POS_W-1:0]         snap_len;
    logic signed [SUM_W-1:0]  snap_total;
    logic signed [SUM_W-1:0]  snap_min;
    logic [IDX_W-1:0]         snap_min_idx;
    logic signed [SUM_W-1:0]  snap_max;
    logic [IDX_W-1:0]         snap_max_idx;
    logic [IDX_W-1:0]         snap_run_begin;
    logic [POS_W-1:0]         snap_run_len;

    // register writes, unused indices are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                rqt_pkg::REG_THRESHOLD:
                begin
                    cfg_next.threshold = cfg_data[rqt_pkg::Q_W-1:0];
                end
                rqt_pkg::REG_MIN_LENGTH:
                begin
                    cfg_next.min_length = cfg_data[rqt_pkg::MINLEN_W-1:0];
                end
                rqt_pkg::REG_TRIM_MODE:
                begin
                    cfg_next.mode = rqt_pkg::mode_t'(cfg_data[1:0]);
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // a plain base always moves on; a last base needs room in the snapshot
    assign advance  = in_valid_reg && (!last_reg || snap_free);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= rqt_pkg::THRESHOLD_RESET;
            cfg_reg.min_length <= rqt_pkg::MIN_LENGTH_RESET;
            cfg_reg.mode       <= rqt_pkg::MODE_RESET;
            in_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            quality_reg <= quality_code;
            last_reg    <= last_base;
        end
    end

    rqt_tracker #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .threshold      (cfg_reg.threshold),
        .base_valid     (advance),
        .base_quality   (quality_reg),
        .base_last      (last_reg),
        .snap_ready     (snap_ready),
        .snap_free      (snap_free),
        .snap_valid     (snap_valid),
        .snap_len       (snap_len),
        .snap_total     (snap_total),
        .snap_min       (snap_min),
        .snap_min_idx   (snap_min_idx),
        .snap_max       (snap_max),
        .snap_max_idx   (snap_max_idx),
        .snap_run_begin (snap_run_begin),
        .snap_run_len   (snap_run_len)
    );

    rqt_resolve #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_resolve (
        .clk            (clk),
        .rst_n          (rst_n),
        .min_length     (cfg_reg.min_length),
        .mode           (cfg_reg.mode),
        .snap_valid     (snap_valid),
        .snap_ready     (snap_ready),
        .snap_len       (snap_len),
        .snap_total     (snap_total),
        .snap_min       (snap_min),
        .snap_min_idx   (snap_min_idx),
        .snap_max       (snap_max),
        .snap_max_idx   (snap_max_idx),
        .snap_run_begin (snap_run_begin),
        .snap_run_len   (snap_run_len),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .trim_start     (trim_start),
        .trim_end       (trim_end),
        .keep_read      (keep_read)
    );

endmodule

`default_nettype wire

FILE: design/rqt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rqt_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          last_base,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [rqt_pkg::OUT_W-1:0]     trim_start,
    input  wire logic [rqt_pkg::OUT_W-1:0]     trim_end,
    input  wire logic                          keep_read
);

    // reads closed at the input but not yet delivered
    logic [1:0] pending_reg, pending_next;
    logic       read_in;
    logic       read_out;

    assign read_in  = in_valid && in_ready && last_base;
    assign read_out = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + 2'(read_in) - 2'(read_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(trim_start)
            && $stable(trim_end) && $stable(keep_read))
    else $error("result changed while stalled");

    // no result without a closed read
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
    else $error("result without a closed read");

    // nothing waiting means bases are always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd0 |-> in_ready)
    else $error("input blocked with no read outstanding");

    // at most three reads in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd3 |-> !(in_ready && in_valid && last_base))
    else $error("fourth read taken in");

endmodule

bind read_quality_trimmer rqt_checker u_rqt_checker (.*);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import rqt_pkg::*;

    // one base as it waits for the driver
    typedef struct {
        logic [Q_W-1:0] quality;
        logic           last;
    } base_item_t;

    // one trimming result, as predicted or as seen on the output channel
    typedef struct packed {
        logic [OUT_W-1:0] first_idx;
        logic [OUT_W-1:0] last_idx;
        logic             keep;
    } trim_result_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic [Q_W-1:0]         quality_code = '0;
    logic                   last_base    = 1'b0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [OUT_W-1:0]       trim_start;
    logic [OUT_W-1:0]       trim_end;
    logic                   keep_read;

    read_quality_trimmer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .quality_code (quality_code),
        .last_base    (last_base),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .trim_start   (trim_start),
        .trim_end     (trim_end),
        .keep_read    (keep_read)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bases queued for the driver, and those not yet accepted by the block
    base_item_t   base_queue[$];
    int           bases_in_flight = 0;
    // predicted results still waiting for their output transaction
    trim_result_t trim_expected[$];

    int mismatch_count = 0;
    int bases_taken    = 0;
    int reads_checked  = 0;
    int cfg_writes     = 0;
    int longest_read   = 0;
    int mode_reads[4]  = '{0, 0, 0, 0};
    bit base_taken     = 1'b0;

    // shadow of the configuration registers, updated on every write transaction
    logic [Q_W-1:0]      cfg_thr    = THRESHOLD_RESET;
    logic [MINLEN_W-1:0] cfg_minlen = MIN_LENGTH_RESET;
    mode_t               cfg_mode   = MODE_RESET;

    // running state of the read being trimmed
    int read_pos  = 0;      // index of the next base
    int psum      = 0;      // prefix sum of threshold minus quality
    int pmin      = 0;
    int pmin_at   = 0;
    int pmax      = 0;
    int pmax_at   = 0;
    bit in_run    = 1'b0;
    int run_from  = 0;
    int best_from = 0;
    int best_len  = 0;

    // advance the trimmer state by one base; gives a result on the last base
    function automatic bit trim_predict(input logic [Q_W-1:0] q, input logic last,
                                        output trim_result_t res);
        int s;
        int e;
        res = '0;
        // bases past the length limit only count for their last mark
        if (read_pos < MAX_READ_LEN)
        begin
            psum += int'(cfg_thr) - int'(q);
            if (read_pos == 0)
            begin
                pmin    = psum;
                pmin_at = 0;
                pmax    = psum;
                pmax_at = 0;
            end
            else
            begin
                // strict compares keep the first extreme
                if (psum < pmin)
                begin
                    pmin    = psum;
                    pmin_at = read_pos;
                end
                if (psum > pmax)
                begin
                    pmax    = psum;
                    pmax_at = read_pos;
                end
            end
            if (q >= cfg_thr)
            begin
                if (!in_run)
                begin
                    in_run   = 1'b1;
                    run_from = read_pos;
                end
                // strictly longer only, so ties keep the first run
                if (read_pos - run_from + 1 > best_len)
                begin
                    best_len  = read_pos - run_from + 1;
                    best_from = run_from;
                end
            end
            else
            begin
                in_run = 1'b0;
            end
            read_pos++;
        end
        if (!last)
            return 1'b0;

        s = 0;
        e = read_pos - 1;
        case (cfg_mode)
            MODE_RIGHT, MODE_BOTH:
            begin
                // suffix sum after index i is total minus prefix at i
                if (psum - pmin > 0)
                    e = pmin_at;
                if (cfg_mode == MODE_BOTH)
                begin
                    s = pmax_at;
                    if (psum - pmax < 0)
                        s++;
                end
            end
            MODE_RUN:
            begin
                if (best_len > 0)
                begin
                    s = best_from;
                    e = best_from + best_len - 1;
                end
                else
                begin
                    // no good base at all: a single-index window at zero
                    s = 0;
                    e = 0;
                end
            end
            default: ;
        endcase
        res.first_idx = s[OUT_W-1:0];
        res.last_idx  = e[OUT_W-1:0];
        // signed length, so a left cut past the right cut can still pass min 0
        res.keep      = (e - s + 1 >= int'(cfg_minlen));
        mode_reads[cfg_mode]++;
        if (read_pos > longest_read)
            longest_read = read_pos;

        read_pos  = 0;
        psum      = 0;
        pmin      = 0;
        pmin_at   = 0;
        pmax      = 0;
        pmax_at   = 0;
        in_run    = 1'b0;
        run_from  = 0;
        best_from = 0;
        best_len  = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input trim_result_t want,
                                   input trim_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $write("mismatch (%s) at %0t: expected start %0d end %0d keep %0d",
                   what, $realtime, want.first_idx, want.last_idx, want.keep);
            $display(", got start %0d end %0d keep %0d",
                     got.first_idx, got.last_idx, got.keep);
        end
    endtask

    // monitor: everything is sampled on the rising edge, inputs having
    // settled at the falling edge before
    always @(posedge clk)
    begin
        trim_result_t res;
        trim_result_t got;
        trim_result_t want;
        if (rst_n)
        begin
            base_taken <= in_valid && in_ready;
            // input transaction: run the predictor with the current settings
            if (in_valid && in_ready)
            begin
                bases_in_flight--;
                bases_taken++;
                if (trim_predict(quality_code, last_base, res))
                    trim_expected.push_back(res);
            end
            // output transaction: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                got = '{trim_start, trim_end, keep_read};
                reads_checked++;
                if (trim_expected.size() == 0)
                begin
                    report_mismatch("no read pending", '0, got);
                end
                else
                begin
                    want = trim_expected.pop_front();
                    if (got != want)
                        report_mismatch("field", want, got);
                end
            end
            // register write transaction
            if (cfg_write)
            begin
                cfg_writes++;
                case (reg_index_t'(cfg_index))
                    REG_THRESHOLD:  cfg_thr    = cfg_data[Q_W-1:0];
                    REG_MIN_LENGTH: cfg_minlen = cfg_data[MINLEN_W-1:0];
                    REG_TRIM_MODE:  cfg_mode   = mode_t'(cfg_data[1:0]);
                    default: ;
                endcase
            end
        end
        else
        begin
            base_taken <= 1'b0;
        end
    end

    // driver: bursts of random length separated by random gaps; the payload
    // holds until the transaction completes
    int gap_left   = 0;
    int burst_left = 0;

    always @(negedge clk)
    begin
        logic           nv;
        logic [Q_W-1:0] nq;
        logic           nl;
        base_item_t     item;
        nv = in_valid;
        nq = quality_code;
        nl = last_base;
        if (!rst_n)
        begin
            nv = 1'b0;
        end
        else if (!in_valid || base_taken)
        begin
            nv = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (base_queue.size() > 0)
            begin
                item = base_queue.pop_front();
                nv   = 1'b1;
                nq   = item.quality;
                nl   = item.last;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    // a quarter of bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    burst_left = $urandom_range(1, 50);
                end
            end
        end
        in_valid     <= nv;
        quality_code <= nq;
        last_base    <= nl;
    end

    // receiver: its own stall pattern, switching style every so often
    int ready_style = 0;
    int ready_hold  = 0;
    int stall_left  = 0;

    always @(negedge clk)
    begin
        logic nr;
        if (ready_hold == 0)
        begin
            ready_style = $urandom_range(0, 3);
            ready_hold  = $urandom_range(20, 200);
        end
        else
        begin
            ready_hold--;
        end
        case (ready_style)
            0: nr = 1'b1;
            1: nr = $urandom_range(0, 1);
            2: nr = ($urandom_range(0, 3) == 0);
            default:
            begin
                // mostly ready, with occasional long stalls
                if (stall_left > 0)
                begin
                    nr = 1'b0;
                    stall_left--;
                end
                else
                begin
                    nr = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(10, 40);
                end
            end
        endcase
        out_ready <= nr;
    end

    task automatic add_base(input logic [Q_W-1:0] q, input logic last);
        base_item_t item;
        item.quality = q;
        item.last    = last;
        base_queue.push_back(item);
        bases_in_flight++;
    endtask

    // quality bytes clustered round the threshold, with extremes mixed in
    function automatic logic [Q_W-1:0] pick_quality(input int thr);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                v = thr + int'($urandom_range(0, 30)) - 15;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
            8:       v = 0;
            9:       v = 255;
            default: v = $urandom_range(0, 255);
        endcase
        return v[Q_W-1:0];
    endfunction

    task automatic add_read(input int len, input int thr, input bit close);
        for (int i = 0; i < len; i++)
            add_base(pick_quality(thr), close && (i == len - 1));
    endtask

    // the sender holds off until every base is taken and every result is in,
    // then pauses on so the pipeline has emptied
    task automatic wait_idle();
        while (bases_in_flight != 0 || trim_expected.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input int thr, input int minlen, input mode_t mode);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MIN_LENGTH, minlen);
        write_reg(REG_TRIM_MODE, mode);
    endtask

    // stimulus
    initial
    begin
        int    phase;
        int    rand_bases;
        int    thr;
        int    minlen;
        int    n_reads;
        int    len;
        mode_t mode;
        bit    open_read;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults straight out of reset
        add_base(8'd0, 1'b0); add_base(8'd255, 1'b0); add_base(8'd48, 1'b1);
        wait_idle();

        // no trimming: single base read, and a read of all zero quality
        set_config(48, 0, MODE_NONE);
        add_base(8'd255, 1'b1);
        add_base(8'd0, 1'b0); add_base(8'd0, 1'b1);
        wait_idle();

        // both sides: left cut lands past the right cut, length 0 then -1
        set_config(48, 0, MODE_BOTH);
        add_base(8'd99, 1'b0); add_base(8'd0, 1'b1);
        add_base(8'd99, 1'b0); add_base(8'd0, 1'b0); add_base(8'd0, 1'b1);
        wait_idle();

        // longest run: no good base, then equal runs where the first must win
        set_config(255, 1, MODE_RUN);
        add_base(8'd0, 1'b0); add_base(8'd254, 1'b1);
        add_base(8'd255, 1'b0); add_base(8'd0, 1'b0); add_base(8'd255, 1'b1);
        wait_idle();

        // zero threshold: every base good, nothing to cut
        set_config(0, 4096, MODE_RIGHT);
        add_base(8'd0, 1'b0); add_base(8'd255, 1'b1);
        wait_idle();

        // settings changed part way through a read
        set_config(48, 25, MODE_RIGHT);
        add_base(8'd10, 1'b0); add_base(8'd200, 1'b0);
        wait_idle();
        set_config(100, 2, MODE_BOTH);
        add_base(8'd30, 1'b0); add_base(8'd90, 1'b1);
        wait_idle();

        // random phases: new settings each time, short reads, and sometimes
        // a read left open across the settings change
        phase      = 0;
        rand_bases = 0;
        open_read  = 1'b0;
        while (rand_bases < 600)
        begin
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = 255;
                2:       thr = $urandom_range(0, 255);
                default: thr = $urandom_range(20, 60);
            endcase
            case ($urandom_range(0, 5))
                0:       minlen = 0;
                1:       minlen = 4096;
                2:       minlen = $urandom_range(0, 4096);
                default: minlen = $urandom_range(0, 20);
            endcase
            mode = (phase < 4) ? mode_t'(phase) : mode_t'($urandom_range(0, 3));
            set_config(thr, minlen, mode);

            n_reads = $urandom_range(4, 10);
            for (int r = 0; r < n_reads; r++)
            begin
                len = $urandom_range(1, 24);
                add_read(len, thr, 1'b1);
                rand_bases += len;
            end
            open_read = ($urandom_range(0, 3) == 0);
            if (open_read)
            begin
                len = $urandom_range(1, 6);
                add_read(len, thr, 1'b0);
                rand_bases += len;
            end
            wait_idle();
            phase++;
        end
        if (open_read)
            add_base(pick_quality(thr), 1'b1);
        wait_idle();

        $display("run covered %0d bases in %0d reads (longest %0d) over %0d register writes",
                 bases_taken, reads_checked, longest_read, cfg_writes);
        $display("reads per mode: none %0d, right %0d, both %0d, run %0d; mismatches %0d",
                 mode_reads[0], mode_reads[1], mode_reads[2], mode_reads[3],
                 mismatch_count);
        if (mismatch_count == 0 && trim_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: read_quality_trimmer.f
design/rqt_pkg.sv
design/rqt_tracker.sv
design/rqt_resolve.sv
design/read_quality_trimmer.sv
design/rqt_checker.sv
dv/tb.sv
